[rtl/pearson_correlation_engine_assert.svh]
// assertion macros for the pearson correlation engine
// needs clk and rst_n in the scope of each use
`ifndef PEARSON_CORRELATION_ENGINE_ASSERT_SVH
`define PEARSON_CORRELATION_ENGINE_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define PCE_ASSERT_IMP(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);
// next-cycle implication
`define PCE_ASSERT_NXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);
`else
`define PCE_ASSERT_IMP(label, pre, post, msg)
`define PCE_ASSERT_NXT(label, pre, post, msg)
`endif
`endif

[rtl/pce_pkg.sv]
// shared types and constants of the pearson correlation engine
// no dependencies
`default_nettype none
package pce_pkg;

    localparam int Q_BITS = 16;
    localparam int BIT_W  = 4;
    localparam int RHS_SHIFT = 30;

    // result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_ZERO_VAR = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    // serial multiply operations
    typedef enum logic [2:0] {
        OP_N_SXY   = 3'd0,
        OP_SX_SY   = 3'd1,
        OP_N_SXX   = 3'd2,
        OP_SX_SX   = 3'd3,
        OP_N_SYY   = 3'd4,
        OP_SY_SY   = 3'd5,
        OP_VX_VY   = 3'd6,
        OP_NUM_NUM = 3'd7
    } op_t;

    typedef struct packed {
        logic             acc_en;
        logic             mul_start;
        op_t              op;
        logic             mul_store;
        logic             search_init;
        logic             try_shift;
        logic             try_add;
        logic             decide;
        logic [BIT_W-1:0] bit_idx;
        logic             finish;
    } pce_cmd_t;

    typedef struct packed {
        logic mul_done;
        logic last_pending;
        logic out_blocked;
    } pce_sts_t;

endpackage
`default_nettype wire

[rtl/pce_mul.sv]
// shift-and-add signed multiplier, one multiplier bit per cycle
// depends on nothing
`default_nettype none
module pce_mul #(
    parameter int WIDTH = 56
) (
    input  wire                       clk,
    input  wire                       rst_n,
    input  wire                       start,
    input  wire  signed [WIDTH-1:0]   a,
    input  wire  signed [WIDTH-1:0]   b,
    output logic signed [2*WIDTH-1:0] prod,
    output logic                      done
);
    localparam int CNT_W = $clog2(WIDTH + 1);

    logic [2*WIDTH-1:0] ma_reg, acc_reg;
    logic [WIDTH-1:0]   mb_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               neg_reg, busy_reg, done_reg;

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(WIDTH);
            end
            else if (busy_reg)
            begin
                if (cnt_reg != '0)
                    cnt_reg <= cnt_reg - 1'b1;
                else
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // magnitudes, partial sum and final sign fix
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            ma_reg  <= (2*WIDTH)'(a[WIDTH-1] ? WIDTH'(-a) : WIDTH'(a));
            mb_reg  <= b[WIDTH-1] ? WIDTH'(-b) : WIDTH'(b);
            neg_reg <= a[WIDTH-1] ^ b[WIDTH-1];
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg != '0)
            begin
                if (mb_reg[0])
                    acc_reg <= acc_reg + ma_reg;
                ma_reg <= ma_reg << 1;
                mb_reg <= mb_reg >> 1;
            end
            else if (neg_reg)
                acc_reg <= -acc_reg;
        end
    end

    assign prod = signed'(acc_reg);
    assign done = done_reg;
endmodule
`default_nettype wire

[rtl/pce_ctrl.sv]
// sequencer of the pearson correlation engine
// depends on pce_pkg and pearson_correlation_engine_assert.svh
`default_nettype none
`include "pearson_correlation_engine_assert.svh"
module pce_ctrl (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire pce_pkg::pce_sts_t sts,
    output pce_pkg::pce_cmd_t      cmd
);
    import pce_pkg::*;

    typedef enum logic [2:0] {
        S_ACC, S_MSTART, S_MWAIT, S_SINIT, S_TRY1, S_TRY2, S_DECIDE, S_FINISH
    } state_t;

    state_t           state_reg;
    op_t              op_reg;
    logic [BIT_W-1:0] bit_reg;

    // state, operation and bit counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_ACC;
            op_reg    <= OP_N_SXY;
            bit_reg   <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_ACC:
                begin
                    if (sts.last_pending)
                    begin
                        op_reg    <= OP_N_SXY;
                        state_reg <= S_MSTART;
                    end
                end
                S_MSTART: state_reg <= S_MWAIT;
                S_MWAIT:
                begin
                    if (sts.mul_done)
                    begin
                        if (op_reg == OP_NUM_NUM)
                            state_reg <= S_SINIT;
                        else
                        begin
                            op_reg    <= op_t'(op_reg + 3'd1);
                            state_reg <= S_MSTART;
                        end
                    end
                end
                S_SINIT:
                begin
                    bit_reg   <= BIT_W'(Q_BITS - 1);
                    state_reg <= S_TRY1;
                end
                S_TRY1: state_reg <= S_TRY2;
                S_TRY2: state_reg <= S_DECIDE;
                S_DECIDE:
                begin
                    if (bit_reg == '0)
                        state_reg <= S_FINISH;
                    else
                    begin
                        bit_reg   <= bit_reg - 1'b1;
                        state_reg <= S_TRY1;
                    end
                end
                S_FINISH:
                begin
                    if (!sts.out_blocked)
                        state_reg <= S_ACC;
                end
                default: state_reg <= S_ACC;
            endcase
        end
    end

    // command decode
    always_comb
    begin
        cmd             = '0;
        cmd.op          = op_reg;
        cmd.bit_idx     = bit_reg;
        cmd.acc_en      = (state_reg == S_ACC);
        cmd.mul_start   = (state_reg == S_MSTART);
        cmd.mul_store   = (state_reg == S_MWAIT) && sts.mul_done;
        cmd.search_init = (state_reg == S_SINIT);
        cmd.try_shift   = (state_reg == S_TRY1);
        cmd.try_add     = (state_reg == S_TRY2);
        cmd.decide      = (state_reg == S_DECIDE);
        cmd.finish      = (state_reg == S_FINISH) && !sts.out_blocked;
    end

    `PCE_ASSERT_IMP(a_done_in_wait, sts.mul_done, state_reg == S_MWAIT, "multiply done outside wait")
    `PCE_ASSERT_IMP(a_last_in_acc, sts.last_pending, state_reg == S_ACC, "last pair outside accumulate")
    `PCE_ASSERT_NXT(a_finish_returns, cmd.finish, state_reg == S_ACC, "finish did not return")
endmodule
`default_nettype wire

[rtl/pce_datapath.sv]
// accumulators, moment arithmetic and coefficient search
// depends on pce_pkg and pce_mul
`default_nettype none
module pce_datapath #(
    parameter int MAX_PAIRS   = 1024,
    parameter int SAMPLE_BITS = 16
) (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire pce_pkg::pce_cmd_t cmd,
    output pce_pkg::pce_sts_t      sts,
    input  wire                    s_axis_tvalid,
    output logic                   s_axis_tready,
    input  wire  [31:0]            s_axis_tdata,
    input  wire                    s_axis_tlast,
    output logic                   m_axis_tvalid,
    input  wire                    m_axis_tready,
    output logic [31:0]            m_axis_tdata
);
    import pce_pkg::*;

    localparam int SW  = SAMPLE_BITS;
    localparam int XW  = (SW > 16) ? SW : 16;
    localparam int CW  = $clog2(MAX_PAIRS + 1);
    localparam int SXW = SW + CW;
    localparam int SQW = 2 * SW + CW;
    localparam int PW  = 2 * (SW + CW) + 2;
    localparam int DW  = 2 * PW;
    localparam int RW  = 2 * PW + 33;

    logic [XW-1:0]        xz, yz;
    logic signed [SW-1:0] xs, ys;
    logic                 accept;

    logic                   a_acc_reg, a_last_reg;
    logic signed [SW-1:0]   a_x_reg, a_y_reg;
    logic signed [2*SW-1:0] a_xy_reg, a_xx_reg, a_yy_reg;

    logic [CW-1:0]         pairs_reg;
    logic                  ovf_reg;
    logic signed [SXW-1:0] sx_reg, sy_reg;
    logic signed [SQW-1:0] sxy_reg, sxx_reg, syy_reg;

    logic signed [PW-1:0]   num_reg, vx_reg, vy_reg, mul_a, mul_b;
    logic signed [2*PW-1:0] prod;
    logic                   mul_done;
    logic [DW-1:0]          den_reg;
    logic [RW-1:0]          rhs_reg, q_acc_reg, p_acc_reg, t_reg, den_ext;
    logic [Q_BITS-1:0]      q_reg;

    logic                  out_valid_reg;
    logic [31:0]           out_data_reg;
    logic                  zero_var;
    logic signed [15:0]    r_val;
    logic [1:0]            st_val;

    // sample fields, low SAMPLE_BITS bits taken as two's complement
    assign xz     = XW'(s_axis_tdata[15:0]);
    assign yz     = XW'(s_axis_tdata[31:16]);
    assign xs     = signed'(xz[SW-1:0]);
    assign ys     = signed'(yz[SW-1:0]);
    assign s_axis_tready = cmd.acc_en && !a_last_reg;
    assign accept = s_axis_tvalid && s_axis_tready;

    // product stage and pair counting
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_acc_reg  <= 1'b0;
            a_last_reg <= 1'b0;
            pairs_reg  <= '0;
            ovf_reg    <= 1'b0;
        end
        else if (cmd.finish)
        begin
            pairs_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            a_acc_reg  <= accept && (pairs_reg < CW'(MAX_PAIRS));
            a_last_reg <= accept && s_axis_tlast;
            if (accept)
            begin
                if (pairs_reg < CW'(MAX_PAIRS))
                    pairs_reg <= pairs_reg + 1'b1;
                else
                    ovf_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_x_reg  <= xs;
            a_y_reg  <= ys;
            a_xy_reg <= xs * ys;
            a_xx_reg <= xs * xs;
            a_yy_reg <= ys * ys;
        end
    end

    // running sums
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sx_reg  <= '0;
            sy_reg  <= '0;
            sxy_reg <= '0;
            sxx_reg <= '0;
            syy_reg <= '0;
        end
        else if (cmd.finish)
        begin
            sx_reg  <= '0;
            sy_reg  <= '0;
            sxy_reg <= '0;
            sxx_reg <= '0;
            syy_reg <= '0;
        end
        else if (a_acc_reg)
        begin
            sx_reg  <= sx_reg + SXW'(a_x_reg);
            sy_reg  <= sy_reg + SXW'(a_y_reg);
            sxy_reg <= sxy_reg + SQW'(a_xy_reg);
            sxx_reg <= sxx_reg + SQW'(a_xx_reg);
            syy_reg <= syy_reg + SQW'(a_yy_reg);
        end
    end

    // multiplier operand select
    always_comb
    begin
        mul_a = PW'(sx_reg);
        mul_b = PW'(sy_reg);
        unique case (cmd.op)
            OP_N_SXY:
            begin
                mul_a = PW'({1'b0, pairs_reg});
                mul_b = PW'(sxy_reg);
            end
            OP_SX_SY:
            begin
                mul_a = PW'(sx_reg);
                mul_b = PW'(sy_reg);
            end
            OP_N_SXX:
            begin
                mul_a = PW'({1'b0, pairs_reg});
                mul_b = PW'(sxx_reg);
            end
            OP_SX_SX:
            begin
                mul_a = PW'(sx_reg);
                mul_b = PW'(sx_reg);
            end
            OP_N_SYY:
            begin
                mul_a = PW'({1'b0, pairs_reg});
                mul_b = PW'(syy_reg);
            end
            OP_SY_SY:
            begin
                mul_a = PW'(sy_reg);
                mul_b = PW'(sy_reg);
            end
            OP_VX_VY:
            begin
                mul_a = vx_reg;
                mul_b = vy_reg;
            end
            OP_NUM_NUM:
            begin
                mul_a = num_reg;
                mul_b = num_reg;
            end
            default: ;
        endcase
    end

    pce_mul #(.WIDTH(PW)) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .prod  (prod),
        .done  (mul_done)
    );

    // covariance and variance terms
    always_ff @(posedge clk)
    begin
        if (cmd.mul_store)
        begin
            case (cmd.op)
                OP_N_SXY:   num_reg <= signed'(prod[PW-1:0]);
                OP_SX_SY:   num_reg <= num_reg - signed'(prod[PW-1:0]);
                OP_N_SXX:   vx_reg  <= signed'(prod[PW-1:0]);
                OP_SX_SX:   vx_reg  <= vx_reg - signed'(prod[PW-1:0]);
                OP_N_SYY:   vy_reg  <= signed'(prod[PW-1:0]);
                OP_SY_SY:   vy_reg  <= vy_reg - signed'(prod[PW-1:0]);
                OP_VX_VY:   den_reg <= DW'(prod);
                OP_NUM_NUM: rhs_reg <= RW'({prod, RHS_SHIFT'(0)});
                default: ;
            endcase
        end
    end

    // bitwise search for q with q*q*den <= num*num*2^30
    assign den_ext = RW'(den_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.search_init)
        begin
            q_acc_reg <= '0;
            p_acc_reg <= '0;
            q_reg     <= '0;
        end
        else if (cmd.try_shift)
            t_reg <= q_acc_reg + (p_acc_reg << ({1'b0, cmd.bit_idx} + 5'd1));
        else if (cmd.try_add)
            t_reg <= t_reg + (den_ext << {cmd.bit_idx, 1'b0});
        else if (cmd.decide)
        begin
            if (t_reg <= rhs_reg)
            begin
                q_acc_reg          <= t_reg;
                p_acc_reg          <= p_acc_reg + (den_ext << cmd.bit_idx);
                q_reg[cmd.bit_idx] <= 1'b1;
            end
        end
    end

    // result formatting
    assign zero_var = (vx_reg == '0) || (vy_reg == '0);

    always_comb
    begin
        if (zero_var)
            r_val = '0;
        else if (num_reg[PW-1])
            r_val = signed'(-q_reg);
        else if (q_reg[Q_BITS-1])
            r_val = 16'sh7FFF;
        else
            r_val = signed'(q_reg);
        if (ovf_reg)
            st_val = ST_OVERFLOW;
        else if (zero_var)
            st_val = ST_ZERO_VAR;
        else
            st_val = ST_OK;
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.finish)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
            out_data_reg <= {3'b000, st_val, 11'(pairs_reg), r_val};
    end

    assign m_axis_tvalid    = out_valid_reg;
    assign m_axis_tdata     = out_data_reg;
    assign sts.mul_done     = mul_done;
    assign sts.last_pending = a_last_reg;
    assign sts.out_blocked  = out_valid_reg && !m_axis_tready;
endmodule
`default_nettype wire

[rtl/pearson_correlation_engine.sv]
// Pearson correlation engine: takes one (x, y) pair per cycle on the input stream and
// accumulates n, Sx, Sy, Sxy, Sxx and Syy. The pair marked by tlast closes the data set:
// input ready then drops while eight serial multiplies form the covariance and variance
// terms and a 16-step bitwise search finds r; the result is held back while a previous
// result still waits on the output. The shared shift-and-add multiplier handles one bit
// per cycle. r comes out in Q1.15, truncated toward zero, +1.0 held at 32767. Status 1
// flags a zero variance (r is 0), status 2 flags pairs dropped beyond MAX_PAIRS. A waiting
// result is held in an output register while the next data set streams in.
// depends on pce_pkg, pce_ctrl and pce_datapath
`default_nettype none
module pearson_correlation_engine #(
    parameter int MAX_PAIRS   = 1024,
    parameter int SAMPLE_BITS = 16
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [31:0] s_axis_tdata,   // x_sample[15:0], y_sample[31:16]
    input  wire         s_axis_tlast,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [31:0] m_axis_tdata    // correlation[15:0], pair_count[26:16], status[28:27]
);
    import pce_pkg::*;

    pce_cmd_t cmd;
    pce_sts_t sts;

    pce_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    pce_datapath #(
        .MAX_PAIRS   (MAX_PAIRS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );
endmodule
`default_nettype wire

[bench/tb_top.sv]
// self-checking bench for pearson_correlation_engine: directed and random sample streams, exact r predictor
// depends on pce_pkg and the engine rtl
`default_nettype none
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import pce_pkg::*;

    localparam int MAX_N      = 1024;
    localparam int QUIET_MAX  = 20000;

    typedef struct packed {
        logic [1:0]  status;
        logic [10:0] pair_count;
        logic [15:0] correlation;
    } corr_result_t;

    // running sums of the data set, exact
    class corr_scoreboard;
        int           pairs;
        longint       sx, sy;
        logic signed [63:0] sxy, sxx, syy;
        bit           dropped;
        corr_result_t pending[$];
        int           errors;

        function void clear();
            pairs = 0; sx = 0; sy = 0; sxy = 0; sxx = 0; syy = 0; dropped = 0;
        endfunction

        // search for r with q*q*den <= num*num*2^30
        function corr_result_t close_set();
            logic signed [255:0] nn, vx, vy, num, den, rhs, t;
            logic [16:0] q, c;
            corr_result_t res;
            nn  = pairs;
            num = nn * sxy - 256'(sx) * 256'(sy);
            vx  = nn * sxx - 256'(sx) * 256'(sx);
            vy  = nn * syy - 256'(sy) * 256'(sy);
            res.pair_count = pairs[10:0];
            if (vx == 0 || vy == 0) begin
                res.correlation = '0;
                res.status = ST_ZERO_VAR;
            end
            else begin
                den = vx * vy;
                if (num < 0) t = -num; else t = num;
                rhs = (t * t) <<< RHS_SHIFT;
                q = 0;
                for (int b = 15; b >= 0; b--)
                begin
                    c = q | (17'd1 << b);
                    if (256'(c) * 256'(c) * den <= rhs) q = c;
                end
                if (num < 0) res.correlation = 16'(-q);
                else res.correlation = (q > 32767) ? 16'd32767 : q[15:0];
                res.status = ST_OK;
            end
            if (dropped) res.status = ST_OVERFLOW;
            return res;
        endfunction

        function void note_request(logic signed [15:0] x, logic signed [15:0] y, logic lst);
            if (pairs < MAX_N) begin
                pairs++; sx += x; sy += y;
                sxy += x * y; sxx += x * x; syy += y * y;
            end
            else dropped = 1;
            if (lst) begin
                pending.push_back(close_set());
                clear();
            end
        endfunction

        task check_result(corr_result_t got);
            corr_result_t exp_r;
            if (pending.size() == 0) begin
                report_mismatch("result with none expected", got, got);
                return;
            end
            exp_r = pending.pop_front();
            if (got.correlation !== exp_r.correlation)
                report_mismatch("correlation", got, exp_r);
            if (got.pair_count !== exp_r.pair_count)
                report_mismatch("pair_count", got, exp_r);
            if (got.status !== exp_r.status)
                report_mismatch("status", got, exp_r);
        endtask

        task report_mismatch(string what, corr_result_t got, corr_result_t exp_r);
            errors++;
            $display("mismatch %s: got %h expected %h", what, got, exp_r);
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;   // x_sample[15:0], y_sample[31:16]
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // correlation[15:0], pair_count[26:16], status[28:27]

    corr_scoreboard board;
    bit  send_done;
    bit  quiet_tail;
    bit  hold_off;
    int  quiet_cycles;

    pearson_correlation_engine dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    initial clk = 0;
    always #10 clk = ~clk;

    // one request, held until accepted, with random idle bursts first
    task automatic send_pair(logic [15:0] x, logic [15:0] y, logic lst);
        if (!quiet_tail && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {y, x};
        s_axis_tlast  <= lst;
        do @(posedge clk); while (!s_axis_tready);
        board.note_request(x, y, lst);
    endtask

    function automatic logic [15:0] rand_sample(int mode);
        case (mode)
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'($urandom_range(0, 15)) - 16'd8;
            default: return 16'($urandom);
        endcase
    endfunction

    // a data set of a chosen kind (independent, noisy or exact linear relation, or constant y) so r spans its range
    task automatic send_set(int len, int kind);
        logic [15:0] x, y;
        int slope;
        slope = $urandom_range(0, 1) ? 1 : -1;
        for (int i = 0; i < len; i++)
        begin
            x = rand_sample($urandom_range(0, 5));
            case (kind)
                0: y = rand_sample($urandom_range(0, 5));
                1: y = 16'(slope * $signed(x) / 2 + $signed(16'($urandom_range(0, 63))) - 32);
                2: y = 16'(slope * $signed(x) / 2);
                default: y = 16'h1234;
            endcase
            send_pair(x, y, i == len - 1);
        end
    endtask

    // stimulus
    initial
    begin
        int sent;
        board = new();
        board.clear();
        board.errors = 0;
        rst_n = 0;
        s_axis_tvalid = 0; s_axis_tdata = 0; s_axis_tlast = 0;
        send_done = 0; quiet_tail = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        // directed: single pair, extremes, perfect correlation both ways, constant y
        send_pair(16'h8000, 16'h7fff, 1);
        send_pair(16'h8000, 16'h8000, 0);
        send_pair(16'h7fff, 16'h7fff, 1);
        send_pair(16'h8000, 16'h7fff, 0);
        send_pair(16'h7fff, 16'h8000, 1);
        send_pair(16'd1, 16'd5, 0);
        send_pair(16'd2, 16'd5, 0);
        send_pair(16'd3, 16'd5, 1);
        send_pair(16'hffff, 16'h0000, 0);
        send_pair(16'h0000, 16'hffff, 0);
        send_pair(16'h5555, 16'haaaa, 1);
        // too many samples: one oversize set
        for (int i = 0; i < MAX_N + 3; i++)
            send_pair(16'($urandom), 16'($urandom), i == MAX_N + 2);
        // random sets, mostly short
        sent = 0;
        while (sent < 750)
        begin
            int len;
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
            if (sent > 600) quiet_tail = 1;
            send_set(len, $urandom_range(0, 3));
            sent += len;
        end
        s_axis_tvalid <= 1'b0;
        s_axis_tlast  <= 1'b0;
        send_done = 1;
    end

    // long receiver hold-off to fill the engine
    initial
    begin
        hold_off = 0;
        wait (rst_n);
        repeat (50) @(posedge clk);
        hold_off = 1;
        repeat (3000) @(posedge clk);
        hold_off = 0;
    end

    // receiver with random stall bursts
    initial
    begin
        int stall;
        m_axis_tready = 0;
        stall = 0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
                board.check_result(corr_result_t'(m_axis_tdata[28:0] >> 0 & 29'h7ffffff
                    | (29'(m_axis_tdata[28:27]) << 27)));
            if (stall > 0) stall--;
            else if (!quiet_tail && $urandom_range(0, 5) == 0) stall = $urandom_range(1, 7);
            m_axis_tready <= !hold_off && stall == 0;
        end
    end

    // watchdog and end of run
    initial
    begin
        quiet_cycles = 0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_MAX)
            begin
                $display("[pearson_correlation_engine] ERROR");
                $finish;
            end
            else if (send_done && board.pending.size() == 0)
            begin
                repeat (600) @(posedge clk);
                if (board.errors == 0 && board.pending.size() == 0)
                    $display("[pearson_correlation_engine] OK");
                else
                    $display("[pearson_correlation_engine] ERROR");
                $finish;
            end
        end
    end
endmodule
`default_nettype wire
